>>> rtl/ihs_pkg.sv
// ----------------------------------------------------------------------------
// ihs_pkg
// Shared types, codes and constants of the image header sniffer.
// ----------------------------------------------------------------------------
package ihs_pkg;

	typedef enum logic [4:0] {
		PH_SOI     = 5'd0,
		PH_JMARKA  = 5'd1,
		PH_JAPPLEN = 5'd2,
		PH_JSKIPA  = 5'd3,
		PH_JMARKB  = 5'd4,
		PH_JDQTLEN = 5'd5,
		PH_JSKIPD  = 5'd6,
		PH_JSOFLEN = 5'd7,
		PH_JPREC   = 5'd8,
		PH_JHEIGHT = 5'd9,
		PH_JWIDTH  = 5'd10,
		PH_JCOMP   = 5'd11,
		PH_PSIG1   = 5'd12,
		PH_PSIG2   = 5'd13,
		PH_PSIG3   = 5'd14,
		PH_PLEN    = 5'd15,
		PH_PTYPE   = 5'd16,
		PH_PWIDTH  = 5'd17,
		PH_PHEIGHT = 5'd18,
		PH_PDEPTH  = 5'd19,
		PH_PCOLOR  = 5'd20,
		PH_DONE    = 5'd21
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_UNKNOWN   = 3'd1,
		ST_BAD_PREC  = 3'd2,
		ST_BAD_COLOR = 3'd3,
		ST_NO_FRAME  = 3'd4,
		ST_TRUNC     = 3'd5,
		ST_BAD_SEG   = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		FMT_NONE = 2'd0,
		FMT_JPEG = 2'd1,
		FMT_PNG  = 2'd2
	} fmt_t;

	localparam logic [31:0] MK_SOI      = 32'h0000_FFD8;
	localparam logic [31:0] MK_APP_LO   = 32'h0000_FFE0;
	localparam logic [31:0] MK_APP_HI   = 32'h0000_FFEF;
	localparam logic [31:0] MK_COM      = 32'h0000_FFFE;
	localparam logic [31:0] MK_DQT      = 32'h0000_FFDB;
	localparam logic [31:0] MK_SOF0     = 32'h0000_FFC0;
	localparam logic [31:0] MK_SOF2     = 32'h0000_FFC2;
	localparam logic [31:0] PNG_SIG1    = 32'h0000_8950;
	localparam logic [31:0] PNG_SIG2    = 32'h0000_4E47;
	localparam logic [31:0] PNG_SIG3    = 32'h0000_0D0A;
	localparam logic [31:0] PNG_SIG4    = 32'h0000_1A0A;
	localparam logic [31:0] IHDR_LEN    = 32'd13;
	localparam logic [31:0] IHDR_TYPE   = 32'h4948_4452;
	localparam logic [31:0] JPEG_PREC   = 32'd8;
	localparam logic [31:0] SEG_LEN_MIN = 32'd2;

	localparam logic [7:0] CT_GRAY       = 8'd0;
	localparam logic [7:0] CT_RGB        = 8'd2;
	localparam logic [7:0] CT_PALETTE    = 8'd3;
	localparam logic [7:0] CT_GRAY_ALPHA = 8'd4;
	localparam logic [7:0] CT_RGB_ALPHA  = 8'd6;

	typedef struct packed {
		status_t      status;
		fmt_t         format;
		logic [31:0]  width;
		logic [31:0]  height;
		logic [7:0]   precision;
		logic [7:0]   components;
		logic [7:0]   palette_bits;
		logic [15:0]  bits_per_pixel;
		logic [31:0]  file_length;
	} hdr_result_t;

	function automatic logic [2:0] field_len(input phase_t ph);
		logic [2:0] n;
		unique case (ph)
			PH_PLEN, PH_PTYPE, PH_PWIDTH, PH_PHEIGHT: n = 3'd4;
			PH_SOI, PH_JMARKA, PH_JAPPLEN, PH_JMARKB, PH_JDQTLEN, PH_JSOFLEN,
			PH_JHEIGHT, PH_JWIDTH, PH_PSIG1, PH_PSIG2, PH_PSIG3: n = 3'd2;
			default: n = 3'd1;
		endcase
		return n;
	endfunction

endpackage

>>> rtl/ihs_parser.sv
// ----------------------------------------------------------------------------
// ihs_parser
// Header state machine: gathers big-endian fields, skips segments, keeps the
// header fields and byte count, and forms the result for the last byte.
// ----------------------------------------------------------------------------
module ihs_parser import ihs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  byte_value,
	input  logic        last_byte,
	output hdr_result_t res
);

	phase_t      phase_q, phase_n;
	logic [2:0]  cnt_q, cnt_n, cnt_inc;
	logic [31:0] shift_q, shift_n, v;
	logic [15:0] skip_q, skip_n, skip_dec;
	fmt_t        fmt_q, fmt_n;
	logic [31:0] width_q, width_n;
	logic [31:0] height_q, height_n;
	logic [7:0]  prec_q, prec_n;
	logic [7:0]  comp_q, comp_n;
	logic [7:0]  pal_q, pal_n;
	status_t     status_q, status_n;
	logic [31:0] total_q, total_n;
	status_t     st;
	logic        ok;
	logic [7:0]  prec_o, comp_o;

	always_comb begin : next_state
		phase_n  = phase_q;
		cnt_n    = cnt_q;
		shift_n  = shift_q;
		skip_n   = skip_q;
		fmt_n    = fmt_q;
		width_n  = width_q;
		height_n = height_q;
		prec_n   = prec_q;
		comp_n   = comp_q;
		pal_n    = pal_q;
		status_n = status_q;
		total_n  = (total_q == 32'hFFFF_FFFF) ? total_q : total_q + 32'd1;
		v        = {shift_q[23:0], byte_value};
		cnt_inc  = cnt_q + 3'd1;
		skip_dec = (skip_q != 16'd0) ? skip_q - 16'd1 : skip_q;

		if (phase_q == PH_DONE) begin
			phase_n = PH_DONE;
		end else if (phase_q == PH_JSKIPA || phase_q == PH_JSKIPD) begin
			skip_n = skip_dec;
			if (skip_dec == 16'd0)
				phase_n = (phase_q == PH_JSKIPA) ? PH_JMARKA : PH_JMARKB;
		end else begin
			shift_n = v;
			cnt_n   = cnt_inc;
			if (cnt_inc >= field_len(phase_q)) begin
				cnt_n   = 3'd0;
				shift_n = 32'd0;
				unique case (phase_q)
					PH_SOI: begin
						if (v == MK_SOI) begin
							fmt_n   = FMT_JPEG;
							phase_n = PH_JMARKA;
						end else if (v == PNG_SIG1) begin
							phase_n = PH_PSIG1;
						end else begin
							status_n = ST_UNKNOWN;
							phase_n  = PH_DONE;
						end
					end
					PH_JMARKA, PH_JMARKB: begin
						if (phase_q == PH_JMARKA &&
							((v >= MK_APP_LO && v <= MK_APP_HI) || v == MK_COM))
							phase_n = PH_JAPPLEN;
						else if (v == MK_DQT)
							phase_n = PH_JDQTLEN;
						else if (v == MK_SOF0 || v == MK_SOF2)
							phase_n = PH_JSOFLEN;
						else begin
							status_n = ST_NO_FRAME;
							phase_n  = PH_DONE;
						end
					end
					PH_JAPPLEN, PH_JDQTLEN: begin
						if (v < SEG_LEN_MIN) begin
							status_n = ST_BAD_SEG;
							phase_n  = PH_DONE;
						end else if (v == SEG_LEN_MIN) begin
							phase_n = (phase_q == PH_JAPPLEN) ? PH_JMARKA : PH_JMARKB;
						end else begin
							skip_n  = v[15:0] - SEG_LEN_MIN[15:0];
							phase_n = (phase_q == PH_JAPPLEN) ? PH_JSKIPA : PH_JSKIPD;
						end
					end
					PH_JSOFLEN: phase_n = PH_JPREC;
					PH_JPREC: begin
						prec_n = v[7:0];
						if (v != JPEG_PREC) begin
							status_n = ST_BAD_PREC;
							phase_n  = PH_DONE;
						end else begin
							phase_n = PH_JHEIGHT;
						end
					end
					PH_JHEIGHT: begin
						height_n = v;
						phase_n  = PH_JWIDTH;
					end
					PH_JWIDTH: begin
						width_n = v;
						phase_n = PH_JCOMP;
					end
					PH_JCOMP: begin
						comp_n   = v[7:0];
						pal_n    = 8'd0;
						status_n = ST_OK;
						phase_n  = PH_DONE;
					end
					PH_PSIG1, PH_PSIG2, PH_PSIG3, PH_PLEN: begin
						if ((phase_q == PH_PSIG1 && v == PNG_SIG2) ||
							(phase_q == PH_PSIG2 && v == PNG_SIG3) ||
							(phase_q == PH_PSIG3 && v == PNG_SIG4) ||
							(phase_q == PH_PLEN && v == IHDR_LEN))
							phase_n = phase_t'(phase_q + 5'd1);
						else begin
							status_n = ST_UNKNOWN;
							phase_n  = PH_DONE;
						end
					end
					PH_PTYPE: begin
						if (v == IHDR_TYPE) begin
							fmt_n   = FMT_PNG;
							phase_n = PH_PWIDTH;
						end else begin
							status_n = ST_UNKNOWN;
							phase_n  = PH_DONE;
						end
					end
					PH_PWIDTH: begin
						width_n = v;
						phase_n = PH_PHEIGHT;
					end
					PH_PHEIGHT: begin
						height_n = v;
						phase_n  = PH_PDEPTH;
					end
					PH_PDEPTH: begin
						prec_n  = v[7:0];
						phase_n = PH_PCOLOR;
					end
					PH_PCOLOR: begin
						pal_n    = 8'd0;
						status_n = ST_OK;
						phase_n  = PH_DONE;
						unique case (v[7:0])
							CT_GRAY:       comp_n = 8'd1;
							CT_RGB:        comp_n = 8'd3;
							CT_GRAY_ALPHA: comp_n = 8'd2;
							CT_RGB_ALPHA:  comp_n = 8'd4;
							CT_PALETTE: begin
								comp_n = 8'd0;
								pal_n  = prec_q;
								prec_n = 8'd0;
							end
							default: status_n = ST_BAD_COLOR;
						endcase
					end
					default: begin
						status_n = ST_UNKNOWN;
						phase_n  = PH_DONE;
					end
				endcase
			end
		end
	end

	always_comb begin : outputs
		st     = (phase_n == PH_DONE) ? status_n : ST_TRUNC;
		ok     = (st == ST_OK);
		prec_o = ok ? prec_n : 8'd0;
		comp_o = ok ? comp_n : 8'd0;
		res.status         = st;
		res.format         = fmt_n;
		res.width          = ok ? width_n : 32'd0;
		res.height         = ok ? height_n : 32'd0;
		res.precision      = prec_o;
		res.components     = comp_o;
		res.palette_bits   = ok ? pal_n : 8'd0;
		res.bits_per_pixel = {8'd0, prec_o} * {8'd0, comp_o};
		res.file_length    = total_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SOI;
			cnt_q    <= 3'd0;
			shift_q  <= 32'd0;
			skip_q   <= 16'd0;
			fmt_q    <= FMT_NONE;
			width_q  <= 32'd0;
			height_q <= 32'd0;
			prec_q   <= 8'd0;
			comp_q   <= 8'd0;
			pal_q    <= 8'd0;
			status_q <= ST_OK;
			total_q  <= 32'd0;
		end else if (step) begin
			if (last_byte) begin
				phase_q  <= PH_SOI;
				cnt_q    <= 3'd0;
				shift_q  <= 32'd0;
				skip_q   <= 16'd0;
				fmt_q    <= FMT_NONE;
				width_q  <= 32'd0;
				height_q <= 32'd0;
				prec_q   <= 8'd0;
				comp_q   <= 8'd0;
				pal_q    <= 8'd0;
				status_q <= ST_OK;
				total_q  <= 32'd0;
			end else begin
				phase_q  <= phase_n;
				cnt_q    <= cnt_n;
				shift_q  <= shift_n;
				skip_q   <= skip_n;
				fmt_q    <= fmt_n;
				width_q  <= width_n;
				height_q <= height_n;
				prec_q   <= prec_n;
				comp_q   <= comp_n;
				pal_q    <= pal_n;
				status_q <= status_n;
				total_q  <= total_n;
			end
		end
	end

endmodule

>>> rtl/image_header_sniffer.sv
// ----------------------------------------------------------------------------
// image_header_sniffer
// Recognizes a JPEG or PNG header in a byte stream and reports the image
// parameters and file length once per file.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid / in_ready  byte_value, last_byte
//  out      out_valid/out_ready  status, format, width, height, precision,
//                                components, palette_bits, bits_per_pixel,
//                                file_length
//
// A byte is held in the input register, then steps the header state machine;
// the result of the last byte lands in the output register as that byte
// steps. One byte per cycle, but a full output register stalls a last byte,
// and only a last byte, in the input register; other bytes keep flowing.
// Reset clears the parser to wait for the first byte of a file.
// ----------------------------------------------------------------------------
module image_header_sniffer import ihs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  byte_value,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [1:0]  format,
	output logic [31:0] width,
	output logic [31:0] height,
	output logic [7:0]  precision,
	output logic [7:0]  components,
	output logic [7:0]  palette_bits,
	output logic [15:0] bits_per_pixel,
	output logic [31:0] file_length
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        step;
	logic        out_valid_q;
	hdr_result_t res;
	hdr_result_t res_q;

	assign step     = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= byte_value;
			last_s1 <= last_byte;
		end
	end

	ihs_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.byte_value (byte_s1),
		.last_byte  (last_s1),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			res_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = res_q.status;
	assign format         = res_q.format;
	assign width          = res_q.width;
	assign height         = res_q.height;
	assign precision      = res_q.precision;
	assign components     = res_q.components;
	assign palette_bits   = res_q.palette_bits;
	assign bits_per_pixel = res_q.bits_per_pixel;
	assign file_length    = res_q.file_length;

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for image_header_sniffer. Directed files cover the
// JPEG and PNG header paths, every status code and the field extremes, and
// random JPEG, PNG and noise files follow, some of them cut short. A parser
// model inside the bench predicts the one result per file, and a monitor
// compares each result transaction field by field with that prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import ihs_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int RANDOM_BYTES   = 480;
	localparam int RANDOM_FILES   = 10;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} byte_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  byte_value = 8'd0;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  status;
	logic [1:0]  format;
	logic [31:0] width;
	logic [31:0] height;
	logic [7:0]  precision;
	logic [7:0]  components;
	logic [7:0]  palette_bits;
	logic [15:0] bits_per_pixel;
	logic [31:0] file_length;

	image_header_sniffer dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.byte_value(byte_value),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.format(format),
		.width(width),
		.height(height),
		.precision(precision),
		.components(components),
		.palette_bits(palette_bits),
		.bits_per_pixel(bits_per_pixel),
		.file_length(file_length)
	);

	always #4 clk = ~clk;

	byte_item_t  byte_queue[$];
	logic [7:0]  file_buf[$];
	hdr_result_t expected_headers[$];

	int mismatches = 0;
	int quiet_cycles = 0;
	int send_wait = 0;
	int take_wait = 0;
	int sent_count = 0;
	int taken_count = 0;
	logic in_fire = 1'b0;
	logic out_fire = 1'b0;

	// header parser state
	phase_t      sn_phase;
	logic [2:0]  sn_count;
	logic [31:0] sn_shift;
	logic [31:0] sn_skip;
	fmt_t        sn_fmt;
	logic [31:0] sn_width;
	logic [31:0] sn_height;
	logic [7:0]  sn_prec;
	logic [7:0]  sn_comp;
	logic [7:0]  sn_pal;
	status_t     sn_status;
	logic [31:0] sn_total;

	task automatic clear_parser();
		sn_phase = PH_SOI;
		sn_count = 3'd0;
		sn_shift = 32'd0;
		sn_skip = 32'd0;
		sn_fmt = FMT_NONE;
		sn_width = 32'd0;
		sn_height = 32'd0;
		sn_prec = 8'd0;
		sn_comp = 8'd0;
		sn_pal = 8'd0;
		sn_status = ST_OK;
		sn_total = 32'd0;
	endtask

	task automatic conclude(input status_t st);
		sn_status = st;
		sn_phase = PH_DONE;
	endtask

	task automatic take_marker(input logic [31:0] v, input bit app_ok);
		if (app_ok && ((v >= MK_APP_LO && v <= MK_APP_HI) || v == MK_COM))
			sn_phase = PH_JAPPLEN;
		else if (v == MK_DQT)
			sn_phase = PH_JDQTLEN;
		else if (v == MK_SOF0 || v == MK_SOF2)
			sn_phase = PH_JSOFLEN;
		else
			conclude(ST_NO_FRAME);
	endtask

	task automatic take_length(input logic [31:0] v, input phase_t skip_ph,
			input phase_t back_ph);
		if (v < SEG_LEN_MIN) begin
			conclude(ST_BAD_SEG);
		end else if (v == SEG_LEN_MIN) begin
			sn_phase = back_ph;
		end else begin
			sn_skip = v - SEG_LEN_MIN;
			sn_phase = skip_ph;
		end
	endtask

	task automatic sniff_byte(input logic [7:0] b, input logic last);
		logic [31:0] v;
		int need;
		status_t st;
		bit ok;
		hdr_result_t r;
		if (sn_total != 32'hFFFF_FFFF)
			sn_total++;
		if (sn_phase == PH_DONE) begin
		end else if (sn_phase == PH_JSKIPA || sn_phase == PH_JSKIPD) begin
			if (sn_skip != 0)
				sn_skip--;
			if (sn_skip == 0)
				sn_phase = (sn_phase == PH_JSKIPA) ? PH_JMARKA : PH_JMARKB;
		end else begin
			case (sn_phase)
				PH_PLEN, PH_PTYPE, PH_PWIDTH, PH_PHEIGHT: need = 4;
				PH_JPREC, PH_JCOMP, PH_PDEPTH, PH_PCOLOR: need = 1;
				default: need = 2;
			endcase
			sn_shift = {sn_shift[23:0], b};
			sn_count++;
			if (sn_count >= need) begin
				v = sn_shift;
				sn_count = 3'd0;
				sn_shift = 32'd0;
				case (sn_phase)
					PH_SOI: begin
						if (v == MK_SOI) begin
							sn_fmt = FMT_JPEG;
							sn_phase = PH_JMARKA;
						end else if (v == PNG_SIG1) begin
							sn_phase = PH_PSIG1;
						end else begin
							conclude(ST_UNKNOWN);
						end
					end
					PH_JMARKA: take_marker(v, 1'b1);
					PH_JMARKB: take_marker(v, 1'b0);
					PH_JAPPLEN: take_length(v, PH_JSKIPA, PH_JMARKA);
					PH_JDQTLEN: take_length(v, PH_JSKIPD, PH_JMARKB);
					PH_JSOFLEN: sn_phase = PH_JPREC;
					PH_JPREC: begin
						sn_prec = v[7:0];
						if (v != JPEG_PREC)
							conclude(ST_BAD_PREC);
						else
							sn_phase = PH_JHEIGHT;
					end
					PH_JHEIGHT: begin
						sn_height = v;
						sn_phase = PH_JWIDTH;
					end
					PH_JWIDTH: begin
						sn_width = v;
						sn_phase = PH_JCOMP;
					end
					PH_JCOMP: begin
						sn_comp = v[7:0];
						sn_pal = 8'd0;
						conclude(ST_OK);
					end
					PH_PSIG1: if (v == PNG_SIG2) sn_phase = PH_PSIG2; else conclude(ST_UNKNOWN);
					PH_PSIG2: if (v == PNG_SIG3) sn_phase = PH_PSIG3; else conclude(ST_UNKNOWN);
					PH_PSIG3: if (v == PNG_SIG4) sn_phase = PH_PLEN; else conclude(ST_UNKNOWN);
					PH_PLEN: if (v == IHDR_LEN) sn_phase = PH_PTYPE; else conclude(ST_UNKNOWN);
					PH_PTYPE: begin
						if (v == IHDR_TYPE) begin
							sn_fmt = FMT_PNG;
							sn_phase = PH_PWIDTH;
						end else begin
							conclude(ST_UNKNOWN);
						end
					end
					PH_PWIDTH: begin
						sn_width = v;
						sn_phase = PH_PHEIGHT;
					end
					PH_PHEIGHT: begin
						sn_height = v;
						sn_phase = PH_PDEPTH;
					end
					PH_PDEPTH: begin
						sn_prec = v[7:0];
						sn_phase = PH_PCOLOR;
					end
					PH_PCOLOR: begin
						sn_pal = 8'd0;
						case (v[7:0])
							CT_GRAY: begin
								sn_comp = 8'd1;
								conclude(ST_OK);
							end
							CT_RGB: begin
								sn_comp = 8'd3;
								conclude(ST_OK);
							end
							CT_PALETTE: begin
								sn_comp = 8'd0;
								sn_pal = sn_prec;
								sn_prec = 8'd0;
								conclude(ST_OK);
							end
							CT_GRAY_ALPHA: begin
								sn_comp = 8'd2;
								conclude(ST_OK);
							end
							CT_RGB_ALPHA: begin
								sn_comp = 8'd4;
								conclude(ST_OK);
							end
							default: conclude(ST_BAD_COLOR);
						endcase
					end
					default: conclude(ST_UNKNOWN);
				endcase
			end
		end
		if (last) begin
			st = (sn_phase == PH_DONE) ? sn_status : ST_TRUNC;
			ok = (st == ST_OK);
			r.status = st;
			r.format = sn_fmt;
			r.width = ok ? sn_width : 32'd0;
			r.height = ok ? sn_height : 32'd0;
			r.precision = ok ? sn_prec : 8'd0;
			r.components = ok ? sn_comp : 8'd0;
			r.palette_bits = ok ? sn_pal : 8'd0;
			r.bits_per_pixel = {8'd0, r.precision} * {8'd0, r.components};
			r.file_length = sn_total;
			expected_headers.push_back(r);
			clear_parser();
		end
	endtask

	task automatic compare_field(input string tag, input logic [31:0] exp_v,
			input logic [31:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t %s mismatch: expected %0h actual %0h", $time, tag, exp_v, got_v);
			mismatches++;
		end
	endtask

	// stimulus construction
	task automatic put8(input logic [7:0] b);
		file_buf.push_back(b);
	endtask

	task automatic put16(input logic [15:0] v);
		put8(v[15:8]);
		put8(v[7:0]);
	endtask

	task automatic put32(input logic [31:0] v);
		put16(v[31:16]);
		put16(v[15:0]);
	endtask

	task automatic put_segment(input logic [15:0] marker, input int len);
		put16(marker);
		put16(16'(len));
		if (len > 2)
			repeat (len - 2) put8(8'($urandom));
	endtask

	task automatic put_frame(input logic [15:0] marker, input logic [7:0] prec,
			input logic [15:0] h, input logic [15:0] w, input logic [7:0] comp);
		put16(marker);
		put16(16'($urandom));
		put8(prec);
		put16(h);
		put16(w);
		put8(comp);
	endtask

	task automatic png_head();
		put16(16'(PNG_SIG1));
		put16(16'(PNG_SIG2));
		put16(16'(PNG_SIG3));
		put16(16'(PNG_SIG4));
		put32(IHDR_LEN);
		put32(IHDR_TYPE);
	endtask

	task automatic png_file(input logic [31:0] w, input logic [31:0] h,
			input logic [7:0] depth, input logic [7:0] color);
		png_head();
		put32(w);
		put32(h);
		put8(depth);
		put8(color);
	endtask

	task automatic ship_file(input bit cut);
		int n;
		byte_item_t it;
		n = file_buf.size();
		if (cut)
			n = $urandom_range(1, n);
		for (int i = 0; i < n; i++) begin
			it.data = file_buf[i];
			it.last = (i == n - 1);
			byte_queue.push_back(it);
		end
		file_buf.delete();
	endtask

	function automatic int seg_len_draw();
		int pick;
		pick = $urandom_range(0, 31);
		if (pick == 0)
			return $urandom_range(0, 1);
		else if (pick == 1)
			return $urandom_range(13, 200);
		return $urandom_range(2, 12);
	endfunction

	function automatic logic [15:0] app_marker();
		int k;
		k = $urandom_range(0, 16);
		return (k == 16) ? 16'(MK_COM) : 16'(MK_APP_LO) + 16'(k);
	endfunction

	task automatic random_jpeg();
		int k;
		logic [15:0] mark;
		logic [7:0] prec;
		logic [7:0] comp;
		put16(16'(MK_SOI));
		repeat ($urandom_range(0, 3)) put_segment(app_marker(), seg_len_draw());
		repeat ($urandom_range(0, 2)) put_segment(16'(MK_DQT), seg_len_draw());
		if ($urandom_range(0, 9) == 0)
			put_segment(app_marker(), seg_len_draw());
		k = $urandom_range(0, 9);
		if (k == 0)
			mark = {8'hFF, 8'($urandom)};
		else
			mark = k[0] ? 16'(MK_SOF0) : 16'(MK_SOF2);
		prec = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'(JPEG_PREC);
		comp = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(1, 4));
		put_frame(mark, prec, 16'($urandom), 16'($urandom), comp);
		repeat ($urandom_range(0, 6)) put8(8'($urandom));
	endtask

	task automatic random_png();
		logic [7:0] depth;
		logic [7:0] color;
		depth = ($urandom_range(0, 9) < 8) ? (8'd1 << $urandom_range(0, 4)) : 8'($urandom);
		case ($urandom_range(0, 5))
			0: color = CT_GRAY;
			1: color = CT_RGB;
			2: color = CT_PALETTE;
			3: color = CT_GRAY_ALPHA;
			4: color = CT_RGB_ALPHA;
			default: color = 8'($urandom);
		endcase
		png_file($urandom, $urandom, depth, color);
		repeat ($urandom_range(0, 8)) put8(8'($urandom));
		if ($urandom_range(0, 9) == 0)
			file_buf[$urandom_range(0, 15)] ^= 8'($urandom_range(1, 255));
	endtask

	function automatic int idle_draw(input bit calm);
		return calm ? 0 : $urandom_range(0, 10);
	endfunction

	// input driver
	always @(negedge clk) begin : byte_driver
		byte_item_t it;
		if (arst_n && !(in_valid && !in_fire)) begin
			if (send_wait > 0) begin
				send_wait--;
				in_valid <= 1'b0;
			end else if (byte_queue.size() > 0) begin
				it = byte_queue.pop_front();
				byte_value <= it.data;
				last_byte <= it.last;
				in_valid <= 1'b1;
				sent_count++;
				send_wait = idle_draw((sent_count % 200) < 50);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result sink
	always @(negedge clk) begin : result_sink
		if (arst_n) begin
			if (out_fire) begin
				taken_count++;
				take_wait = idle_draw((taken_count % 16) < 4);
			end
			if (take_wait > 0) begin
				take_wait--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// monitor and watchdog
	always @(posedge clk) begin : header_monitor
		hdr_result_t want;
		if (arst_n) begin
			in_fire <= in_valid && in_ready;
			out_fire <= out_valid && out_ready;
			if (in_valid && in_ready)
				sniff_byte(byte_value, last_byte);
			if (out_valid && out_ready) begin
				if (expected_headers.size() == 0) begin
					$display("%0t unexpected result transaction: expected none actual status %0d",
						$time, status);
					mismatches++;
				end else begin
					want = expected_headers.pop_front();
					compare_field("status", 32'(want.status), 32'(status));
					compare_field("format", 32'(want.format), 32'(format));
					compare_field("width", want.width, width);
					compare_field("height", want.height, height);
					compare_field("precision", 32'(want.precision), 32'(precision));
					compare_field("components", 32'(want.components), 32'(components));
					compare_field("palette_bits", 32'(want.palette_bits), 32'(palette_bits));
					compare_field("bits_per_pixel", 32'(want.bits_per_pixel),
						32'(bits_per_pixel));
					compare_field("file_length", want.file_length, file_length);
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL image_header_sniffer");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin : stimulus
		int base;
		int files;
		int pick;
		logic [7:0] depths[5];
		logic [7:0] colors[5];
		int flip_pos[4];
		clear_parser();

		// single byte, unknown start, JPEG extremes
		put8(8'h00);
		ship_file(1'b0);
		put16(16'hFFFF);
		put8(8'h00);
		ship_file(1'b0);
		put16(16'(MK_SOI));
		put_frame(16'(MK_SOF0), 8'(JPEG_PREC), 16'hFFFF, 16'hFFFF, 8'hFF);
		ship_file(1'b0);
		put16(16'(MK_SOI));
		put_segment(16'(MK_APP_LO), 2);
		put_segment(16'(MK_COM), 4);
		put_segment(16'(MK_APP_HI), 3);
		put_segment(16'(MK_DQT), 3);
		put_segment(16'(MK_DQT), 2);
		put_frame(16'(MK_SOF2), 8'(JPEG_PREC), 16'h0000, 16'h0000, 8'h00);
		put16(16'hFF00);
		ship_file(1'b0);
		// bad precision, APPn after DQT, unknown marker
		put16(16'(MK_SOI));
		put_frame(16'(MK_SOF0), 8'hFF, 16'h0010, 16'h0010, 8'h03);
		put8(8'h5A);
		ship_file(1'b0);
		put16(16'(MK_SOI));
		put_segment(16'(MK_DQT), 2);
		put_segment(16'(MK_APP_LO) + 16'd1, 4);
		ship_file(1'b0);
		put16(16'(MK_SOI));
		put16(16'hFFD9);
		ship_file(1'b0);
		// short segment lengths
		put16(16'(MK_SOI));
		put_segment(16'(MK_APP_LO), 0);
		ship_file(1'b0);
		put16(16'(MK_SOI));
		put_segment(16'(MK_COM), 1);
		ship_file(1'b0);
		put16(16'(MK_SOI));
		put_segment(16'(MK_DQT), 1);
		ship_file(1'b0);
		// end of file inside a skipped segment
		put16(16'(MK_SOI));
		put16(16'(MK_APP_LO));
		put16(16'd10);
		put16(16'h1234);
		put8(8'h56);
		ship_file(1'b0);
		// every PNG color type, then bad ones
		depths = '{8'hFF, 8'h00, 8'h08, 8'h10, 8'h01};
		colors = '{CT_GRAY, CT_RGB, CT_PALETTE, CT_GRAY_ALPHA, CT_RGB_ALPHA};
		png_file(32'hFFFF_FFFF, 32'h0, depths[0], colors[0]);
		ship_file(1'b0);
		png_file(32'h0, 32'hFFFF_FFFF, depths[1], colors[1]);
		ship_file(1'b0);
		for (int i = 2; i < 5; i++) begin
			png_file($urandom, $urandom, depths[i], colors[i]);
			put32($urandom);
			ship_file(1'b0);
		end
		png_file(32'd1, 32'd1, 8'h08, 8'd1);
		ship_file(1'b0);
		png_file(32'd2, 32'd2, 8'h08, 8'd5);
		ship_file(1'b0);
		png_file(32'd3, 32'd3, 8'h08, 8'hFF);
		ship_file(1'b0);
		// signature, IHDR length and IHDR type mismatches
		flip_pos = '{3, 7, 11, 15};
		foreach (flip_pos[i]) begin
			png_head();
			file_buf[flip_pos[i]] ^= 8'h01;
			put8(8'h00);
			ship_file(1'b0);
		end
		// end of file inside the width field
		png_head();
		put16(16'hFFFF);
		ship_file(1'b0);

		base = byte_queue.size();
		files = 0;
		while (byte_queue.size() - base < RANDOM_BYTES || files < RANDOM_FILES) begin
			pick = $urandom_range(0, 19);
			if (pick < 9) begin
				random_jpeg();
			end else if (pick < 18) begin
				random_png();
			end else begin
				repeat ($urandom_range(1, 12)) put8(8'($urandom));
			end
			ship_file($urandom_range(0, 7) == 0);
			files++;
		end

		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		while (byte_queue.size() != 0 || in_valid || expected_headers.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		@(negedge clk);
		if (mismatches == 0 && expected_headers.size() == 0)
			$display("PASS image_header_sniffer");
		else
			$display("FAIL image_header_sniffer");
		$finish;
	end

endmodule
